>>> src/gnce_pkg.sv
// gnce_pkg: types, widths and register codes shared by the grid neighbor
// cell enumerator; no dependencies
package gnce_pkg;

  localparam int MAX_DIM_DEFAULT = 64;

  localparam int COORD_W = 6;
  localparam int SIZE_W  = 7;
  localparam int INDEX_W = 18;
  localparam int PLANE_W = 2 * SIZE_W;
  localparam int PROD_W  = PLANE_W + SIZE_W;
  localparam int CFG_IDX_W = 2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic [COORD_W-1:0] cell_z;
  } cell_t;

  typedef struct packed {
    logic [INDEX_W-1:0] centre_index;
    logic [INDEX_W-1:0] neighbor_index;
    logic               last_of_run;
    logic               out_of_grid;
  } result_t;

  typedef struct packed {
    logic [SIZE_W-1:0] size_x;
    logic [SIZE_W-1:0] size_y;
    logic [SIZE_W-1:0] size_z;
  } grid_size_t;

endpackage

>>> src/gnce_cfg_regs.sv
// gnce_cfg_regs: grid size register file with saturation to the largest axis size
// depends on gnce_pkg
module gnce_cfg_regs import gnce_pkg::*; #(
  parameter int MaxDim = MAX_DIM_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [SIZE_W-1:0]    cfg_data_i,
  output grid_size_t           sizes_o
);

  localparam int SatLim = (MaxDim > (2 ** SIZE_W - 1)) ? (2 ** SIZE_W - 1) : MaxDim;
  localparam logic [SIZE_W-1:0] SatVal = SIZE_W'(SatLim);

  grid_size_t        sizes_q;
  logic [SIZE_W-1:0] wr_val;

  assign wr_val = (cfg_data_i > SatVal) ? SatVal : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sizes_q.size_x <= SIZE_RESET;
      sizes_q.size_y <= SIZE_RESET;
      sizes_q.size_z <= SIZE_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SIZE_X: sizes_q.size_x <= wr_val;
        REG_SIZE_Y: sizes_q.size_y <= wr_val;
        REG_SIZE_Z: sizes_q.size_z <= wr_val;
        default: ;
      endcase
    end
  end

  assign sizes_o = sizes_q;

endmodule

>>> src/grid_neighbor_cell_enumerator_unit.sv
// grid_neighbor_cell_enumerator_unit: top level, sequencer around one shared multiplier
// depends on gnce_pkg and gnce_cfg_regs
//
// Usage:
//   An input transaction (cell_i) is taken at a clock edge with start_i high and
//   busy_o low. The block then emits the linear index of every cell of the 3x3x3
//   block around the centre, clipped at the grid faces, x outermost, z innermost.
//   Each result is on result_o for one cycle, marked by result_valid_o; the last
//   one carries last_of_run. A centre outside the grid gives one result with
//   out_of_grid and last_of_run set and both indices zero.
//   Five setup steps on the shared multiplier (plane size, centre x and y
//   offsets, lower corner x and y offsets) come first, then one result per
//   cycle. An item gives 1 to 27 results; an out-of-grid item skips the
//   setup steps and gives its single result from the error state.
//   busy_o is high from acceptance until the last result is registered.
//   The receiver cannot stall: results are never held.
//   Grid sizes are written on the cfg channel, always ready, indices as in
//   cfg_reg_e; values saturate to MaxDim. Reset sets all sizes to 16 and
//   leaves the block idle with no result pending.
module grid_neighbor_cell_enumerator_unit import gnce_pkg::*; #(
  parameter int MaxDim = MAX_DIM_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  cell_t                cell_i,
  output logic                 result_valid_o,
  output result_t              result_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [SIZE_W-1:0]    cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_PLANE,
    ST_CX,
    ST_CY,
    ST_XL,
    ST_YL,
    ST_RUN
  } state_e;

  grid_size_t sizes;

  gnce_cfg_regs #(
    .MaxDim(MaxDim)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .sizes_o    (sizes)
  );

  assign cfg_ready_o = 1'b1;

  state_e              state_q;
  cell_t               cell_q;
  logic [COORD_W-1:0]  xl_q, xh_q, yl_q, yh_q, zl_q, zh_q;
  logic [COORD_W-1:0]  x_q, y_q, z_q;
  logic [PLANE_W-1:0]  plane_q;
  logic [INDEX_W-1:0]  cx_off_q, cy_off_q, centre_q;
  logic [INDEX_W-1:0]  xoff_q, yoff_q, ylo_off_q;
  logic                result_valid_q;
  result_t             result_q;

  logic                accept;
  logic                outside;
  logic [COORD_W-1:0]  xl_d, xh_d, yl_d, yh_d, zl_d, zh_d;
  logic [PLANE_W-1:0]  mul_a;
  logic [SIZE_W-1:0]   mul_b;
  logic [PROD_W-1:0]   mul_p;
  logic [INDEX_W-1:0]  prod;
  logic [INDEX_W-1:0]  neighbor;

  assign accept  = start_i && (state_q == ST_IDLE);
  assign outside = ({1'b0, cell_i.cell_x} >= sizes.size_x) ||
                   ({1'b0, cell_i.cell_y} >= sizes.size_y) ||
                   ({1'b0, cell_i.cell_z} >= sizes.size_z);

  // neighborhood bounds clipped at the faces
  always_comb begin
    xl_d = (cell_i.cell_x != '0) ? cell_i.cell_x - 1'b1 : cell_i.cell_x;
    yl_d = (cell_i.cell_y != '0) ? cell_i.cell_y - 1'b1 : cell_i.cell_y;
    zl_d = (cell_i.cell_z != '0) ? cell_i.cell_z - 1'b1 : cell_i.cell_z;
    xh_d = (({1'b0, cell_i.cell_x} + 1'b1) < sizes.size_x) ? cell_i.cell_x + 1'b1
                                                           : cell_i.cell_x;
    yh_d = (({1'b0, cell_i.cell_y} + 1'b1) < sizes.size_y) ? cell_i.cell_y + 1'b1
                                                           : cell_i.cell_y;
    zh_d = (({1'b0, cell_i.cell_z} + 1'b1) < sizes.size_z) ? cell_i.cell_z + 1'b1
                                                           : cell_i.cell_z;
  end

  // shared multiplier operand select
  always_comb begin
    case (state_q)
      ST_PLANE: begin
        mul_a = PLANE_W'(sizes.size_y);
        mul_b = sizes.size_z;
      end
      ST_CX: begin
        mul_a = plane_q;
        mul_b = SIZE_W'(cell_q.cell_x);
      end
      ST_CY: begin
        mul_a = PLANE_W'(sizes.size_z);
        mul_b = SIZE_W'(cell_q.cell_y);
      end
      ST_XL: begin
        mul_a = plane_q;
        mul_b = SIZE_W'(xl_q);
      end
      ST_YL: begin
        mul_a = PLANE_W'(sizes.size_z);
        mul_b = SIZE_W'(yl_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p    = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign prod     = mul_p[INDEX_W-1:0];
  assign neighbor = xoff_q + yoff_q + INDEX_W'(z_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= outside ? ST_ERR : ST_PLANE;
          end
        end
        ST_ERR: begin
          result_valid_q <= 1'b1;
          state_q        <= ST_IDLE;
        end
        ST_PLANE: state_q <= ST_CX;
        ST_CX:    state_q <= ST_CY;
        ST_CY:    state_q <= ST_XL;
        ST_XL:    state_q <= ST_YL;
        ST_YL:    state_q <= ST_RUN;
        ST_RUN: begin
          result_valid_q <= 1'b1;
          if ((x_q == xh_q) && (y_q == yh_q) && (z_q == zh_q)) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cell_q <= cell_i;
          xl_q   <= xl_d;
          xh_q   <= xh_d;
          yl_q   <= yl_d;
          yh_q   <= yh_d;
          zl_q   <= zl_d;
          zh_q   <= zh_d;
          x_q    <= xl_d;
          y_q    <= yl_d;
          z_q    <= zl_d;
        end
      end
      ST_ERR: begin
        result_q.centre_index   <= '0;
        result_q.neighbor_index <= '0;
        result_q.last_of_run    <= 1'b1;
        result_q.out_of_grid    <= 1'b1;
      end
      ST_PLANE: plane_q  <= prod[PLANE_W-1:0];
      ST_CX:    cx_off_q <= prod;
      ST_CY:    cy_off_q <= prod;
      ST_XL: begin
        xoff_q   <= prod;
        centre_q <= cx_off_q + cy_off_q + INDEX_W'(cell_q.cell_z);
      end
      ST_YL: begin
        yoff_q    <= prod;
        ylo_off_q <= prod;
      end
      ST_RUN: begin
        result_q.centre_index   <= centre_q;
        result_q.neighbor_index <= neighbor;
        result_q.last_of_run    <= (x_q == xh_q) && (y_q == yh_q) && (z_q == zh_q);
        result_q.out_of_grid    <= 1'b0;
        if (z_q != zh_q) begin
          z_q <= z_q + 1'b1;
        end else begin
          z_q <= zl_q;
          if (y_q != yh_q) begin
            y_q    <= y_q + 1'b1;
            yoff_q <= yoff_q + INDEX_W'(sizes.size_z);
          end else begin
            y_q    <= yl_q;
            yoff_q <= ylo_off_q;
            if (x_q != xh_q) begin
              x_q    <= x_q + 1'b1;
              xoff_q <= xoff_q + INDEX_W'(plane_q);
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule

>>> src/gnce_checker.sv
// gnce_checker: port-level assertions for the grid neighbor cell enumerator
// depends on gnce_pkg; bound to grid_neighbor_cell_enumerator_unit
module gnce_checker import gnce_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    start_i,
  input logic    busy_o,
  input logic    result_valid_o,
  input result_t result_o
);

  // an accepted transaction keeps the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("busy not raised after accepted transaction");

  // error result is a single, zeroed, final result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.out_of_grid |->
      result_o.last_of_run && (result_o.centre_index == '0) &&
      (result_o.neighbor_index == '0))
    else $error("malformed out-of-grid result");

  // nothing follows the final result of a run directly
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.last_of_run |=> !result_valid_o)
    else $error("result right after end of run");

  // a new run never starts with a stray result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> !result_valid_o)
    else $error("result at start of run");

  // the centre index is constant within a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last_of_run |=>
      !result_valid_o || (result_o.centre_index == $past(result_o.centre_index)))
    else $error("centre index changed within run");

endmodule

bind grid_neighbor_cell_enumerator_unit gnce_checker u_gnce_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .result_valid_o(result_valid_o),
  .result_o      (result_o)
);
